// ===== rtl/core/stla_pkg.sv =====
// ----------------------------------------------------------------------------
// stla_pkg
// Shared codes and control types for the session table with liveness aging.
// ----------------------------------------------------------------------------
`default_nettype none

package stla_pkg;

  // field widths fixed by the word format
  localparam int OP_W       = 3;
  localparam int CONN_W     = 16;
  localparam int USER_KEY_W = 32;
  localparam int KIND_W     = 2;
  localparam int STATE_W    = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_IDENTIFY   = 3'd0;
  localparam logic [OP_W-1:0] OP_ENSURE     = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK_ALIVE = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PING   = 2'd2;

  // controller states, also the phase seen by the datapath
  localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STATE_W-1:0] ST_SCAN1  = 3'd1;
  localparam logic [STATE_W-1:0] ST_DECIDE = 3'd2;
  localparam logic [STATE_W-1:0] ST_SCAN2  = 3'd3;
  localparam logic [STATE_W-1:0] ST_TICK_A = 3'd4;
  localparam logic [STATE_W-1:0] ST_TICK_B = 3'd5;
  localparam logic [STATE_W-1:0] ST_STATUS = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic               load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step_ok;
    logic need_scan2;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/stla_in_if.sv =====
// ----------------------------------------------------------------------------
// stla_in_if
// Request channel: one operation word with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface stla_in_if;
  logic                             valid;
  logic                             ready;
  logic [stla_pkg::OP_W-1:0]        op;
  logic [stla_pkg::CONN_W-1:0]      conn_id;
  logic [stla_pkg::USER_KEY_W-1:0]  user_key;

  modport source (output valid, output op, output conn_id, output user_key, input ready);
  modport sink   (input valid, input op, input conn_id, input user_key, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stla_out_if.sv =====
// ----------------------------------------------------------------------------
// stla_out_if
// Response channel: close, ping and status words with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface stla_out_if;
  logic                         valid;
  logic                         ready;
  logic [stla_pkg::KIND_W-1:0]  kind;
  logic [stla_pkg::CONN_W-1:0]  target_conn;
  logic                         ok;
  logic                         last;

  modport source (output valid, output kind, output target_conn, output ok, output last,
                  input ready);
  modport sink   (input valid, input kind, input target_conn, input ok, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stla_ctrl.sv =====
// ----------------------------------------------------------------------------
// stla_ctrl
// Sequencer: walks the slot scans of each operation and hands out the phase
// and slot index to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module stla_ctrl #(
  parameter int SLOT_COUNT = 8,
  parameter int IDX_W      = 3
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  input  wire logic [stla_pkg::OP_W-1:0] req_op,
  output logic                           req_ready,
  input  wire stla_pkg::stat_t           st,
  output stla_pkg::cmd_t                 cmd,
  output logic [IDX_W-1:0]               idx
);

  logic [stla_pkg::STATE_W-1:0] state;
  logic [stla_pkg::STATE_W-1:0] state_next;
  logic [IDX_W-1:0]             idx_next;
  logic                         last_idx;

  assign last_idx = (idx == IDX_W'(SLOT_COUNT - 1));

  // next state and scan index
  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      stla_pkg::ST_IDLE: begin
        if (req_valid) begin
          idx_next = '0;
          if (req_op inside {[stla_pkg::OP_IDENTIFY:stla_pkg::OP_REMOVE]}) begin
            state_next = stla_pkg::ST_SCAN1;
          end else if (req_op == stla_pkg::OP_TICK) begin
            state_next = stla_pkg::ST_TICK_A;
          end else begin
            state_next = stla_pkg::ST_STATUS;
          end
        end
      end
      stla_pkg::ST_SCAN1: begin
        if (last_idx) begin
          state_next = stla_pkg::ST_DECIDE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      stla_pkg::ST_DECIDE: begin
        if (st.step_ok) begin
          idx_next   = '0;
          state_next = st.need_scan2 ? stla_pkg::ST_SCAN2 : stla_pkg::ST_STATUS;
        end
      end
      stla_pkg::ST_SCAN2: begin
        if (st.step_ok) begin
          if (last_idx) begin
            state_next = stla_pkg::ST_STATUS;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      stla_pkg::ST_TICK_A: begin
        if (st.step_ok) begin
          if (last_idx) begin
            state_next = stla_pkg::ST_TICK_B;
            idx_next   = '0;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      stla_pkg::ST_TICK_B: begin
        if (st.step_ok) begin
          if (last_idx) begin
            state_next = stla_pkg::ST_STATUS;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      stla_pkg::ST_STATUS: begin
        if (st.step_ok) begin
          state_next = stla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stla_pkg::ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stla_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // commands out
  assign req_ready = (state == stla_pkg::ST_IDLE);
  assign cmd.state = state;
  assign cmd.load  = (state == stla_pkg::ST_IDLE) && req_valid;

endmodule

`default_nettype wire

// ===== rtl/core/stla_dp.sv =====
// ----------------------------------------------------------------------------
// stla_dp
// Datapath: slot table, per-slot compare, scan trackers and the response
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stla_dp #(
  parameter int SLOT_COUNT = 8,
  parameter int KEY_BITS   = 32,
  parameter int IDX_W      = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire stla_pkg::cmd_t                  cmd,
  input  wire logic [IDX_W-1:0]                idx,
  input  wire logic [stla_pkg::OP_W-1:0]       op,
  input  wire logic [stla_pkg::CONN_W-1:0]     conn_id,
  input  wire logic [stla_pkg::USER_KEY_W-1:0] user_key,
  output stla_pkg::stat_t                      st,
  stla_out_if.source                           rsp
);

  // slot table
  logic                        slot_active [SLOT_COUNT];
  logic                        slot_alive  [SLOT_COUNT];
  logic [stla_pkg::CONN_W-1:0] slot_conn   [SLOT_COUNT];
  logic [KEY_BITS-1:0]         slot_key    [SLOT_COUNT];

  // latched request
  logic [stla_pkg::OP_W-1:0]   op_r;
  logic [stla_pkg::CONN_W-1:0] conn_r;
  logic [KEY_BITS-1:0]         key_r;

  // scan trackers
  logic             fd_first_v, fd_last_v, same_v, free_v;
  logic [IDX_W-1:0] fd_first_i, fd_last_i, same_i, free_i;
  logic [IDX_W-1:0] target_i;
  logic             ok_r;

  // output register
  logic                         out_valid;
  logic [stla_pkg::KIND_W-1:0]  kind_r;
  logic [stla_pkg::CONN_W-1:0]  tconn_r;
  logic                         rok_r;
  logic                         last_r;

  logic                        tgt_v;
  logic [IDX_W-1:0]            act_i;
  logic [IDX_W-1:0]            rd_i;
  logic                        cur_active, cur_alive;
  logic [stla_pkg::CONN_W-1:0] cur_conn;
  logic [KEY_BITS-1:0]         cur_key;
  logic                        key_nz, conn_hit, key_hit, dup_hit, takeover;
  logic                        want_emit, out_room, step_ok, emit_go;
  logic [stla_pkg::KIND_W-1:0] emit_kind;

  // slot picked by the decide step
  always_comb begin
    tgt_v = fd_last_v || same_v || free_v;
    if (op_r == stla_pkg::OP_IDENTIFY) begin
      act_i = fd_last_v ? fd_last_i : (same_v ? same_i : free_i);
    end else begin
      act_i = fd_first_v ? fd_first_i : free_i;
    end
  end

  // single read port of the slot table
  assign rd_i       = (cmd.state == stla_pkg::ST_DECIDE) ? act_i : idx;
  assign cur_active = slot_active[rd_i];
  assign cur_alive  = slot_alive[rd_i];
  assign cur_conn   = slot_conn[rd_i];
  assign cur_key    = slot_key[rd_i];

  // per-slot compares
  assign key_nz   = (key_r != '0);
  assign conn_hit = cur_active && (cur_conn == conn_r);
  assign key_hit  = cur_active && key_nz && (cur_key == key_r);
  assign dup_hit  = (idx != target_i) && key_hit;
  assign takeover = (op_r == stla_pkg::OP_IDENTIFY) && !fd_last_v && same_v;

  // does this step produce a response word
  always_comb begin
    case (cmd.state)
      stla_pkg::ST_DECIDE: want_emit = takeover && (cur_conn != conn_r);
      stla_pkg::ST_SCAN2:  want_emit = dup_hit && (cur_conn != conn_r);
      stla_pkg::ST_TICK_A: want_emit = cur_active && !cur_alive;
      stla_pkg::ST_TICK_B: want_emit = cur_active;
      stla_pkg::ST_STATUS: want_emit = 1'b1;
      default:             want_emit = 1'b0;
    endcase
  end

  assign out_room      = !out_valid || rsp.ready;
  assign step_ok       = !want_emit || out_room;
  assign emit_go       = want_emit && out_room;
  assign st.step_ok    = step_ok;
  assign st.need_scan2 = (op_r == stla_pkg::OP_IDENTIFY) && tgt_v && key_nz;

  always_comb begin
    case (cmd.state)
      stla_pkg::ST_TICK_B: emit_kind = stla_pkg::KIND_PING;
      stla_pkg::ST_STATUS: emit_kind = stla_pkg::KIND_STATUS;
      default:             emit_kind = stla_pkg::KIND_CLOSE;
    endcase
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      conn_r <= conn_id;
      key_r  <= KEY_BITS'(user_key);
    end
  end

  // trackers, status flag and identify target
  always_ff @(posedge clk) begin
    if (rst) begin
      fd_first_v <= 1'b0;
      fd_last_v  <= 1'b0;
      same_v     <= 1'b0;
      free_v     <= 1'b0;
      ok_r       <= 1'b0;
    end else if (cmd.load) begin
      fd_first_v <= 1'b0;
      fd_last_v  <= 1'b0;
      same_v     <= 1'b0;
      free_v     <= 1'b0;
      ok_r       <= 1'b0;
    end else if (step_ok) begin
      case (cmd.state)
        stla_pkg::ST_SCAN1: begin
          if (conn_hit) begin
            if (!fd_first_v) begin
              fd_first_v <= 1'b1;
              fd_first_i <= idx;
            end
            fd_last_v <= 1'b1;
            fd_last_i <= idx;
          end else begin
            if (key_hit) begin
              same_v <= 1'b1;
              same_i <= idx;
            end
            if (!cur_active && !free_v) begin
              free_v <= 1'b1;
              free_i <= idx;
            end
          end
        end
        stla_pkg::ST_DECIDE: begin
          target_i <= act_i;
          case (op_r)
            stla_pkg::OP_IDENTIFY: ok_r <= tgt_v;
            stla_pkg::OP_ENSURE:   ok_r <= fd_first_v || free_v;
            default:               ok_r <= fd_first_v;
          endcase
        end
        stla_pkg::ST_TICK_A: begin
          if (cur_active && !cur_alive) begin
            ok_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_active[i] <= 1'b0;
        slot_alive[i]  <= 1'b0;
      end
    end else if (step_ok) begin
      case (cmd.state)
        stla_pkg::ST_DECIDE: begin
          case (op_r)
            stla_pkg::OP_IDENTIFY: begin
              if (tgt_v) begin
                slot_active[act_i] <= 1'b1;
                slot_alive[act_i]  <= 1'b1;
              end
            end
            stla_pkg::OP_ENSURE: begin
              if (fd_first_v || free_v) begin
                slot_active[act_i] <= 1'b1;
                slot_alive[act_i]  <= 1'b1;
              end
            end
            stla_pkg::OP_MARK_ALIVE: begin
              if (fd_first_v) begin
                slot_alive[act_i] <= 1'b1;
              end
            end
            stla_pkg::OP_REMOVE: begin
              if (fd_first_v) begin
                slot_active[act_i] <= 1'b0;
                slot_alive[act_i]  <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        stla_pkg::ST_SCAN2: begin
          if (dup_hit) begin
            slot_active[idx] <= 1'b0;
            slot_alive[idx]  <= 1'b0;
          end
        end
        stla_pkg::ST_TICK_A: begin
          if (cur_active && !cur_alive) begin
            slot_active[idx] <= 1'b0;
          end
          slot_alive[idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // slot connection and key, only meaningful while the slot is active
  always_ff @(posedge clk) begin
    if (step_ok && (cmd.state == stla_pkg::ST_DECIDE)) begin
      if ((op_r == stla_pkg::OP_IDENTIFY) && tgt_v) begin
        slot_conn[act_i] <= conn_r;
        slot_key[act_i]  <= key_r;
      end else if ((op_r == stla_pkg::OP_ENSURE) && !fd_first_v && free_v) begin
        slot_conn[act_i] <= conn_r;
        slot_key[act_i]  <= '0;
      end
    end
  end

  // response output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      kind_r  <= emit_kind;
      tconn_r <= (cmd.state == stla_pkg::ST_STATUS) ? '0 : cur_conn;
      rok_r   <= (cmd.state == stla_pkg::ST_STATUS) && ok_r;
      last_r  <= (cmd.state == stla_pkg::ST_STATUS);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = kind_r;
  assign rsp.target_conn = tconn_r;
  assign rsp.ok          = rok_r;
  assign rsp.last        = last_r;

endmodule

`default_nettype wire

// ===== rtl/core/session_table_with_liveness_aging.sv =====
// ----------------------------------------------------------------------------
// session_table_with_liveness_aging
// Table of connection slots with identify, ensure, mark-alive, remove and
// heartbeat tick; close and ping words come out ahead of one status word.
// ----------------------------------------------------------------------------
// sequence: ensure, mark alive and remove scan the slots once, then decide, then status;
// identify may add a second scan after decide, tick scans twice; the scans step one
// slot per cycle over the single table read port, and back-pressure stalls them
// requests: one at a time, the next is taken once the status word is registered
// reset: synchronous, clears every slot's active and alive flags
`default_nettype none

module session_table_with_liveness_aging #(
  parameter int SLOT_COUNT = 8,
  parameter int KEY_BITS   = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  stla_in_if.sink    req,
  stla_out_if.source rsp
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  stla_pkg::cmd_t   cmd;
  stla_pkg::stat_t  st;
  logic [IDX_W-1:0] idx;

  // sequencer
  stla_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd),
    .idx       (idx)
  );

  // slot table and response register
  stla_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .KEY_BITS   (KEY_BITS),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .idx      (idx),
    .op       (req.op),
    .conn_id  (req.conn_id),
    .user_key (req.user_key),
    .st       (st),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/core/stla_chk.sv =====
// ----------------------------------------------------------------------------
// stla_chk
// Port-level checks for the session table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stla_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [stla_pkg::KIND_W-1:0]   rsp_kind,
  input wire logic [stla_pkg::CONN_W-1:0]   rsp_target_conn,
  input wire logic                          rsp_ok,
  input wire logic                          rsp_last
);

  // a stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_target_conn) && $stable(rsp_ok) && $stable(rsp_last))
    else $error("stalled response word changed");

  // one request in flight: no request taken in the cycle after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one still in work");

  // the status word and only the status word ends a run
  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_last == (rsp_kind == stla_pkg::KIND_STATUS)))
    else $error("last flag does not match status kind");

  // close and ping words carry no ok, status words carry no connection
  a_word_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp_kind == stla_pkg::KIND_STATUS) && (rsp_target_conn == '0)) ||
      (((rsp_kind == stla_pkg::KIND_CLOSE) || (rsp_kind == stla_pkg::KIND_PING)) && !rsp_ok))
    else $error("malformed response word");

endmodule

bind session_table_with_liveness_aging stla_chk u_stla_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_kind        (rsp.kind),
  .rsp_target_conn (rsp.target_conn),
  .rsp_ok          (rsp.ok),
  .rsp_last        (rsp.last)
);

`default_nettype wire

// ===== tb/sv/tb_session_table_with_liveness_aging.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_session_table_with_liveness_aging
// Drives identify, ensure, mark-alive, remove, tick and unused opcodes into
// the session table and follows every request with a slot-table shadow that
// predicts the close, ping and status words. Each reply word is checked field
// by field against the oldest prediction. Both channels idle at random,
// except during one steady stretch.
// ----------------------------------------------------------------------------

module tb_session_table_with_liveness_aging;

  localparam int OP_W       = stla_pkg::OP_W;
  localparam int CONN_W     = stla_pkg::CONN_W;
  localparam int USER_KEY_W = stla_pkg::USER_KEY_W;
  localparam int KIND_W     = stla_pkg::KIND_W;

  localparam int SLOTS          = 8;
  localparam int KEY_BITS       = 32;
  localparam int IDLE_PCT       = 26;
  localparam int RANDOM_ITEMS   = 444;
  localparam int STEADY_FIRST   = 180;
  localparam int STEADY_LAST    = 280;
  localparam int DRAIN_CYCLES   = 2 * SLOTS + 8;
  localparam int WATCHDOG_LIMIT = 2000;

  // opcodes the block must answer with a bare failed status
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CONN_W-1:0] target_conn;
    logic              ok;
    logic              last;
  } reply_t;

  // shadow of the slot table plus the queue of reply words still owed
  class slot_table_tracker;
    bit                    active  [SLOTS];
    bit                    alive   [SLOTS];
    logic [CONN_W-1:0]     conn_of [SLOTS];
    logic [USER_KEY_W-1:0] key_of  [SLOTS];
    reply_t                pending_replies[$];
    int unsigned           fault_count;

    function new();
      fault_count = 0;
      for (int s = 0; s < SLOTS; s++) clear_slot(s);
    endfunction

    function void clear_slot(int s);
      active[s]  = 1'b0;
      alive[s]   = 1'b0;
      conn_of[s] = '0;
      key_of[s]  = '0;
    endfunction

    function void owe(logic [KIND_W-1:0] kind, logic [CONN_W-1:0] conn, logic ok,
                      logic last);
      reply_t w;
      w.kind        = kind;
      w.target_conn = conn;
      w.ok          = ok;
      w.last        = last;
      pending_replies.push_back(w);
    endfunction

    function int first_with_conn(logic [CONN_W-1:0] conn);
      for (int s = 0; s < SLOTS; s++)
        if (active[s] && conn_of[s] == conn) return s;
      return -1;
    endfunction

    // apply one accepted request and queue the words it causes
    function void take_request(logic [OP_W-1:0] op, logic [CONN_W-1:0] conn,
                               logic [USER_KEY_W-1:0] key);
      int by_conn;
      int by_key;
      int spare;
      int target;
      int closes;
      int s;
      logic ok;
      logic was_active;
      logic [CONN_W-1:0] old_conn;
      logic [CONN_W-1:0] pings[$];
      by_conn = -1;
      by_key  = -1;
      spare   = -1;
      closes  = 0;
      ok      = 1'b0;
      case (op)
        stla_pkg::OP_IDENTIFY: begin
          // own slot wins, then last slot with the same key, then first free
          for (int i = 0; i < SLOTS; i++) begin
            if (active[i] && conn_of[i] == conn) begin
              by_conn = i;
              continue;
            end
            if (active[i] && key != 0 && key_of[i] != 0 && key_of[i] == key) by_key = i;
            if (!active[i] && spare < 0) spare = i;
          end
          target = (by_conn >= 0) ? by_conn : ((by_key >= 0) ? by_key : spare);
          if (target >= 0) begin
            old_conn        = conn_of[target];
            was_active      = active[target];
            conn_of[target] = conn;
            active[target]  = 1'b1;
            alive[target]   = 1'b1;
            key_of[target]  = key;
            ok              = 1'b1;
            // slot taken over from another connection
            if (by_conn < 0 && target == by_key && was_active && old_conn != conn) begin
              owe(stla_pkg::KIND_CLOSE, old_conn, 1'b0, 1'b0);
              closes++;
            end
            // evict other holders of the same identity
            if (key != 0) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (i == target || !active[i] || key_of[i] == 0) continue;
                if (key_of[i] == key) begin
                  if (conn_of[i] != conn && closes < SLOTS) begin
                    owe(stla_pkg::KIND_CLOSE, conn_of[i], 1'b0, 1'b0);
                    closes++;
                  end
                  clear_slot(i);
                end
              end
            end
          end
        end
        stla_pkg::OP_ENSURE: begin
          s = first_with_conn(conn);
          if (s >= 0) begin
            alive[s] = 1'b1;
            ok       = 1'b1;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!active[i]) begin
                conn_of[i] = conn;
                active[i]  = 1'b1;
                alive[i]   = 1'b1;
                key_of[i]  = '0;
                ok         = 1'b1;
                break;
              end
            end
          end
        end
        stla_pkg::OP_MARK_ALIVE: begin
          s = first_with_conn(conn);
          if (s >= 0) begin
            alive[s] = 1'b1;
            ok       = 1'b1;
          end
        end
        stla_pkg::OP_REMOVE: begin
          s = first_with_conn(conn);
          if (s >= 0) begin
            clear_slot(s);
            ok = 1'b1;
          end
        end
        stla_pkg::OP_TICK: begin
          // stale slots are closed in index order, pings follow all closes
          for (int i = 0; i < SLOTS; i++) begin
            if (!active[i]) continue;
            if (!alive[i]) begin
              owe(stla_pkg::KIND_CLOSE, conn_of[i], 1'b0, 1'b0);
              clear_slot(i);
              ok = 1'b1;
              continue;
            end
            alive[i] = 1'b0;
            pings.push_back(conn_of[i]);
          end
          foreach (pings[k]) owe(stla_pkg::KIND_PING, pings[k], 1'b0, 1'b0);
        end
        default: ;
      endcase
      owe(stla_pkg::KIND_STATUS, '0, ok, 1'b1);
    endfunction

    // compare one reply word with the oldest owed word
    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply word: kind %0d target_conn %0h ok %0b last %0b",
               got.kind, got.target_conn, got.ok, got.last);
        fault_count++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        fault_count++;
      end
      if (got.target_conn !== want.target_conn) begin
        $error("target_conn: expected %0h, actual %0h", want.target_conn, got.target_conn);
        fault_count++;
      end
      if (got.ok !== want.ok) begin
        $error("ok: expected %0b, actual %0b", want.ok, got.ok);
        fault_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        fault_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic steady;
  int   quiet_cycles;

  stla_in_if  req_ch ();
  stla_out_if rsp_ch ();

  slot_table_tracker tracker = new();

  session_table_with_liveness_aging #(
    .SLOT_COUNT (SLOTS),
    .KEY_BITS   (KEY_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // reply back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // observe both channels: requests feed the shadow, replies are checked
  always @(posedge clk) begin
    reply_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        tracker.take_request(req_ch.op, req_ch.conn_id, req_ch.user_key);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.kind        = rsp_ch.kind;
        got.target_conn = rsp_ch.target_conn;
        got.ok          = rsp_ch.ok;
        got.last        = rsp_ch.last;
        tracker.check_reply(got);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("session_table_with_liveness_aging: mismatch");
        $finish;
      end
    end
  end

  // present one request word and hold it until taken
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CONN_W-1:0] conn,
                              input logic [USER_KEY_W-1:0] key);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.conn_id  <= conn;
    req_ch.user_key <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // connection ids mostly from a small pool so that slots get reused
  function automatic logic [CONN_W-1:0] pick_conn();
    logic [CONN_W-1:0] pool [10];
    pool = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h00FF,
             16'h1234, 16'h8000, 16'hAAAA, 16'h5555, 16'hFFFF};
    if ($urandom_range(0, 7) == 0) return CONN_W'($urandom_range(0, 65535));
    return pool[$urandom_range(0, 9)];
  endfunction

  // user keys: none, a few shared identities, or anything at all
  function automatic logic [USER_KEY_W-1:0] pick_key();
    logic [USER_KEY_W-1:0] pool [6];
    int r;
    pool = '{32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF,
             32'h8000_0000, 32'hA5A5_5A5A, 32'h5A5A_A5A5};
    r = $urandom_range(0, 11);
    if (r < 2) return USER_KEY_W'($urandom);
    if (r < 5) return '0;
    return pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return stla_pkg::OP_IDENTIFY;
    if (r < 48) return stla_pkg::OP_ENSURE;
    if (r < 70) return stla_pkg::OP_MARK_ALIVE;
    if (r < 80) return stla_pkg::OP_REMOVE;
    if (r < 95) return stla_pkg::OP_TICK;
    return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
  endfunction

  // stimulus
  initial begin
    rst             <= 1'b1;
    steady          <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.op       <= stla_pkg::OP_IDENTIFY;
    req_ch.conn_id  <= '0;
    req_ch.user_key <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: tick, and lookups that find nothing
    send_request(stla_pkg::OP_TICK, 16'h0000, 32'h0);
    send_request(stla_pkg::OP_MARK_ALIVE, 16'h0005, 32'h0);
    send_request(stla_pkg::OP_REMOVE, 16'h0005, 32'h0);
    // ensure at the id extremes, then a repeat that finds its slot
    send_request(stla_pkg::OP_ENSURE, 16'h0000, 32'h0);
    send_request(stla_pkg::OP_ENSURE, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(stla_pkg::OP_ENSURE, 16'h0000, 32'h0);
    // identify without a key, with a fresh key, key takeover, own slot plus duplicate
    send_request(stla_pkg::OP_IDENTIFY, 16'h1234, 32'h0);
    send_request(stla_pkg::OP_IDENTIFY, 16'h2000, 32'hFFFF_FFFF);
    send_request(stla_pkg::OP_IDENTIFY, 16'h2001, 32'hFFFF_FFFF);
    send_request(stla_pkg::OP_IDENTIFY, 16'hFFFF, 32'hFFFF_FFFF);
    // one tick pings everyone, the next closes those not marked alive
    send_request(stla_pkg::OP_TICK, 16'h0000, 32'h0);
    send_request(stla_pkg::OP_MARK_ALIVE, 16'h1234, 32'h0);
    send_request(stla_pkg::OP_TICK, 16'hFFFF, 32'h0);
    // unused opcodes
    send_request(OP_UNUSED_LO, 16'h1234, 32'h0);
    send_request(OP_UNUSED_HI, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(stla_pkg::OP_REMOVE, 16'h1234, 32'h0);
    // fill the table, then ensure and identify with no room left
    for (int i = 0; i <= SLOTS; i++) begin
      send_request(stla_pkg::OP_ENSURE, CONN_W'(16'h0100 + i), 32'h0);
    end
    send_request(stla_pkg::OP_IDENTIFY, 16'h0300, 32'h0000_0055);

    // random traffic with one stretch free of idling on both sides
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= STEADY_FIRST && n < STEADY_LAST);
      send_request(pick_op(), pick_conn(), pick_key());
    end
    req_ch.valid <= 1'b0;
    steady       <= 1'b0;

    // drain, then allow the block's latency before judging
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.fault_count == 0 && tracker.pending_replies.size() == 0) begin
      $display("session_table_with_liveness_aging: match");
    end else begin
      $display("session_table_with_liveness_aging: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/stla_pkg.sv
rtl/core/stla_in_if.sv
rtl/core/stla_out_if.sv
rtl/core/stla_ctrl.sv
rtl/core/stla_dp.sv
rtl/core/session_table_with_liveness_aging.sv
rtl/core/stla_chk.sv
tb/sv/tb_session_table_with_liveness_aging.sv
